FILE: hdl/hmac_sha256_slot_code_unit_macros.svh
`ifndef HMAC_SHA256_SLOT_CODE_UNIT_MACROS_SVH
`define HMAC_SHA256_SLOT_CODE_UNIT_MACROS_SVH
// implication checked on every rising clock edge outside reset
`define HSC_ASSERT_IMPL(label, clk, rst_n, lhs, rhs) \
label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) else $error("label");
// implication checked in the cycle after the antecedent holds
`define HSC_ASSERT_NEXT(label, clk, rst_n, lhs, rhs) \
label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) else $error("label");
`endif

FILE: hdl/hsc_pkg.sv
package hsc_pkg;
    localparam int unsigned CodeChars = 6;
    localparam int unsigned NumOut = 6;
    localparam int unsigned SlotW = 40;
    localparam int unsigned CharW = 7;
    localparam int unsigned KeyWords = 8;
    localparam int unsigned KeyW = 64;
    localparam int unsigned KeyIdxW = 3;
    localparam int unsigned DigitsMax = 13;

    typedef logic [31:0] t_word;
    typedef logic [6:0] t_char;

    function automatic t_word round_k(input logic [5:0] i);
        t_word k [64] = '{
            32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
            32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
            32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
            32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
            32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
            32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
            32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
            32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
            32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
            32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
            32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
        return k[i];
    endfunction

    function automatic t_word init_h(input logic [2:0] i);
        t_word v [8] = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
                         32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
        return v[i];
    endfunction

    function automatic t_char sym(input logic [4:0] i);
        t_char s [32] = '{7'd48, 7'd49, 7'd50, 7'd51, 7'd52, 7'd53, 7'd54, 7'd55, 7'd56, 7'd57,
                          7'd65, 7'd66, 7'd67, 7'd68, 7'd69, 7'd70, 7'd71, 7'd72, 7'd74, 7'd75,
                          7'd77, 7'd78, 7'd80, 7'd81, 7'd82, 7'd83, 7'd84, 7'd86, 7'd87, 7'd88,
                          7'd89, 7'd90};
        return s[i];
    endfunction

    typedef struct packed {
        logic start;
        logic init;
    } t_cmp_ctrl;
endpackage

FILE: hdl/hsc_stream_if.sv
interface hsc_stream_if #(parameter int unsigned W = 8) ();
    logic valid;
    logic ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: hdl/hsc_compress.sv
module hsc_compress (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  hsc_pkg::t_cmp_ctrl  i_ctrl,
    input  logic [511:0]        i_blk,
    output logic                o_done,
    output logic [255:0]        o_h
);
    logic [31:0] r_w [16];
    logic [31:0] r_h [8];
    logic [31:0] r_a, r_b, r_c, r_d, r_e, r_f, r_g, r_hh;
    logic [6:0]  r_cnt;
    logic        r_busy;
    logic [31:0] w_cur, s0, s1, t1, t2, w_new;

    assign w_cur = r_w[0];
    assign s0 = {r_w[1][6:0], r_w[1][31:7]} ^ {r_w[1][17:0], r_w[1][31:18]} ^ (r_w[1] >> 3);
    assign s1 = {r_w[14][16:0], r_w[14][31:17]} ^ {r_w[14][18:0], r_w[14][31:19]}
              ^ (r_w[14] >> 10);
    assign w_new = r_w[0] + s0 + r_w[9] + s1;
    assign t1 = r_hh + ({r_e[5:0], r_e[31:6]} ^ {r_e[10:0], r_e[31:11]} ^ {r_e[24:0], r_e[31:25]})
              + ((r_e & r_f) ^ (~r_e & r_g)) + hsc_pkg::round_k(r_cnt[5:0]) + w_cur;
    assign t2 = ({r_a[1:0], r_a[31:2]} ^ {r_a[12:0], r_a[31:13]} ^ {r_a[21:0], r_a[31:22]})
              + ((r_a & r_b) ^ (r_a & r_c) ^ (r_b & r_c));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
            r_cnt <= '0;
        end else begin
            o_done <= 1'b0;
            if (i_ctrl.start) begin
                r_busy <= 1'b1;
                r_cnt <= '0;
            end else if (r_busy) begin
                if (r_cnt == 7'd63) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
                r_cnt <= r_cnt + 7'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.start) begin
            for (int i = 0; i < 16; i++) r_w[i] <= i_blk[511-32*i -: 32];
            for (int i = 0; i < 8; i++) begin
                if (i_ctrl.init) r_h[i] <= hsc_pkg::init_h(3'(i));
            end
            r_a <= i_ctrl.init ? hsc_pkg::init_h(3'd0) : r_h[0];
            r_b <= i_ctrl.init ? hsc_pkg::init_h(3'd1) : r_h[1];
            r_c <= i_ctrl.init ? hsc_pkg::init_h(3'd2) : r_h[2];
            r_d <= i_ctrl.init ? hsc_pkg::init_h(3'd3) : r_h[3];
            r_e <= i_ctrl.init ? hsc_pkg::init_h(3'd4) : r_h[4];
            r_f <= i_ctrl.init ? hsc_pkg::init_h(3'd5) : r_h[5];
            r_g <= i_ctrl.init ? hsc_pkg::init_h(3'd6) : r_h[6];
            r_hh <= i_ctrl.init ? hsc_pkg::init_h(3'd7) : r_h[7];
        end else if (r_busy) begin
            for (int i = 0; i < 15; i++) r_w[i] <= r_w[i+1];
            r_w[15] <= w_new;
            r_hh <= r_g; r_g <= r_f; r_f <= r_e; r_e <= r_d + t1;
            r_d <= r_c; r_c <= r_b; r_b <= r_a; r_a <= t1 + t2;
            if (r_cnt == 7'd63) begin
                r_h[0] <= r_h[0] + t1 + t2; r_h[1] <= r_h[1] + r_a;
                r_h[2] <= r_h[2] + r_b;     r_h[3] <= r_h[3] + r_c;
                r_h[4] <= r_h[4] + r_d + t1; r_h[5] <= r_h[5] + r_e;
                r_h[6] <= r_h[6] + r_f;     r_h[7] <= r_h[7] + r_g;
            end
        end
    end

    assign o_h = {r_h[0], r_h[1], r_h[2], r_h[3], r_h[4], r_h[5], r_h[6], r_h[7]};
endmodule

FILE: hdl/hmac_sha256_slot_code_unit.sv
// channel | dir | payload
// in_ch   | in  | slot_number[39:0]
// out_ch  | out | char_0..char_5, 7 bits each, packed char_0 low
// An item runs 40 double-dabble steps for the decimal digits (one per slot bit), then four
// compressions on the single round unit (load, 64 rounds, done), then the load of the result
// register before ready returns.
// Reset is synchronous, active low; ready is low while an item is in work.
// A result not yet taken holds in the output register; the next item is accepted and its
// result load stalls until the register is free.
module hmac_sha256_slot_code_unit #(
    parameter int unsigned CODE_CHARS = hsc_pkg::CodeChars
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    hsc_stream_if.sink               in_ch,
    hsc_stream_if.source             out_ch,
    input  logic                     i_cfg_we,
    input  logic [2:0]               i_cfg_idx,
    input  logic [63:0]              i_cfg_data
);
    localparam logic [2:0] S_IDLE = 3'd0, S_DIG = 3'd1, S_RUN = 3'd2, S_WAIT = 3'd3;
    logic [2:0] r_st;
    logic [63:0] r_key [8];
    logic [39:0] r_q;
    logic [4*hsc_pkg::DigitsMax-1:0] r_bcd;
    logic [5:0]  r_bit;
    logic [1:0]  r_ph;
    logic [255:0] r_inner;
    logic [41:0] r_res;
    logic        r_ov;
    hsc_pkg::t_cmp_ctrl r_cc;
    logic        done;
    logic [255:0] hv;
    logic [511:0] kb, blk;
    logic [4*hsc_pkg::DigitsMax-1:0] bcd_adj;
    logic [8*hsc_pkg::DigitsMax-1:0] msg;
    logic [3:0]  len;
    logic [511:0] tail;

    for (genvar g = 0; g < 8; g++) begin : g_kb
        assign kb[511-64*g -: 64] = r_key[g];
    end

    always_comb begin
        len = 4'd1;
        for (int k = 0; k < hsc_pkg::DigitsMax; k++) begin
            bcd_adj[4*k +: 4] = (r_bcd[4*k +: 4] >= 4'd5) ? r_bcd[4*k +: 4] + 4'd3
                                                           : r_bcd[4*k +: 4];
            msg[8*k +: 8] = {4'h3, r_bcd[4*k +: 4]};
            if (r_bcd[4*k +: 4] != 4'd0) len = 4'(k + 1);
        end
    end

    always_comb begin
        tail = '0;
        tail[511 -: 104] = msg << (8 * (13 - len));
        tail[511 - 8*len -: 8] = 8'h80;
        tail[15:0] = 16'(512 + 8 * len);
        unique case (r_ph)
            2'd0: blk = kb ^ {64{8'h36}};
            2'd1: blk = tail;
            2'd2: blk = kb ^ {64{8'h5c}};
            default: blk = {r_inner, 8'h80, 237'd0, 11'd768};
        endcase
    end

    hsc_compress u_cmp (.i_clk, .i_rst_n, .i_ctrl(r_cc), .i_blk(blk), .o_done(done), .o_h(hv));

    assign in_ch.ready = (r_st == S_IDLE);
    assign out_ch.valid = r_ov;
    assign out_ch.data = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 8; i++) r_key[i] <= '0;
        end else if (i_cfg_we) begin
            r_key[i_cfg_idx] <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cc <= '0;
        if (!i_rst_n) begin
            r_st <= S_IDLE;
            r_ov <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) r_ov <= 1'b0;
            unique case (r_st)
                S_IDLE: if (in_ch.valid) begin
                    r_q <= in_ch.data; r_bcd <= '0; r_bit <= '0; r_st <= S_DIG;
                end
                S_DIG: begin
                    r_bcd <= {bcd_adj[4*hsc_pkg::DigitsMax-2:0], r_q[39]};
                    r_q <= {r_q[38:0], 1'b0};
                    r_bit <= r_bit + 6'd1;
                    if (r_bit == 6'd39) begin
                        r_ph <= 2'd0; r_cc <= '{start: 1'b1, init: 1'b1}; r_st <= S_RUN;
                    end
                end
                S_RUN: if (done) begin
                    if (r_ph == 2'd1) r_inner <= hv;
                    if (r_ph == 2'd3) r_st <= S_WAIT;
                    else begin
                        r_ph <= r_ph + 2'd1;
                        r_cc <= '{start: 1'b1, init: (r_ph == 2'd1)};
                    end
                end
                S_WAIT: if (!r_ov) begin
                    for (int j = 0; j < 6; j++)
                        r_res[7*j +: 7] <= (j < CODE_CHARS) ? hsc_pkg::sym(hv[255-8*j-3 -: 5])
                                           : 7'd0;
                    r_ov <= 1'b1; r_st <= S_IDLE;
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end
endmodule

FILE: hdl/hsc_checker.sv
`include "hmac_sha256_slot_code_unit_macros.svh"
module hsc_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic i_in_ready,
    input logic i_out_valid,
    input logic i_out_ready,
    input logic [hsc_pkg::CharW*hsc_pkg::NumOut-1:0] i_out_data
);
    `HSC_ASSERT_NEXT(a_ov_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid)
    `HSC_ASSERT_NEXT(a_od_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, $stable(i_out_data))
    `HSC_ASSERT_NEXT(a_busy, i_clk, i_rst_n, i_in_valid && i_in_ready, !i_in_ready)
    `HSC_ASSERT_NEXT(a_idle_hold, i_clk, i_rst_n, i_in_ready && !i_in_valid, i_in_ready)
endmodule
bind hmac_sha256_slot_code_unit hsc_checker u_chk (.i_clk(i_clk), .i_rst_n(i_rst_n),
    .i_in_valid(in_ch.valid), .i_in_ready(in_ch.ready), .i_out_valid(out_ch.valid),
    .i_out_ready(out_ch.ready), .i_out_data(out_ch.data));
